// File: sv/b64e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character map of the base64url encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int GROUP_W   = 6;
    localparam int CHAR_W    = 7;
    localparam int SLOTS     = 3;   // data characters one item can cause
    localparam int QDEPTH    = 2;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'd65;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'd97;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'd48;
    localparam logic [CHAR_W-1:0] CH_DASH    = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_UNDER   = 7'h5F;
    localparam logic [CHAR_W-1:0] CH_PAD     = 7'h3D;

    typedef logic [GROUP_W-1:0] group_t;

    // One item's work for the output side: data groups, then '=' padding.
    typedef struct packed {
        group_t [SLOTS-1:0] groups;
        logic   [1:0]       n_data;
        logic   [1:0]       n_pad;
        logic               last;
    } desc_t;

    function automatic logic [CHAR_W-1:0] map_group(input group_t g);
        logic [CHAR_W-1:0] gx;
        gx = {1'b0, g};
        if (g <= 6'd25)
        begin
            return gx + CH_UPPER_A;
        end
        else if (g <= 6'd51)
        begin
            return gx + CH_LOWER_A - 7'd26;
        end
        else if (g <= 6'd61)
        begin
            return gx + CH_ZERO - 7'd52;
        end
        else if (g == 6'd62)
        begin
            return CH_DASH;
        end
        return CH_UNDER;
    endfunction

endpackage

// File: sv/b64e_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e channel interfaces
// Valid/ready channels for input bit items and output characters.
// ----------------------------------------------------------------------------
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_bits;
    logic [3:0] bit_count;
    logic       last;

    modport source (output valid, in_bits, bit_count, last, input ready);
    modport sink   (input valid, in_bits, bit_count, last, output ready);
endinterface

interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       end_of_run;
    logic       end_of_stream;

    modport source (output valid, out_char, end_of_run, end_of_stream, input ready);
    modport sink   (input valid, out_char, end_of_run, end_of_stream, output ready);
endinterface

// File: sv/b64e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bit items, forms 6-bit groups and padding count, tracks stream state.
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic            clk,
    input  logic            rst_n,
    b64e_in_if.sink         in_ch,
    output logic            push,
    output b64e_pkg::desc_t push_desc,
    input  logic            push_ready
);
    import b64e_pkg::*;

    logic [4:0] leftover_bits_reg, leftover_bits_next;
    logic [2:0] leftover_count_reg, leftover_count_next;
    logic [1:0] phase_reg, phase_next;
    logic       seen_reg, seen_next;

    logic [3:0]  bc;
    logic [12:0] data;
    logic [12:0] acc;
    logic [3:0]  total;
    logic [3:0]  rem;
    logic [4:0]  rem_val;
    logic        accept;
    logic [2:0]  n_chars;
    desc_t       d;

    assign in_ch.ready = push_ready;
    assign accept      = in_ch.valid && push_ready;

    always_comb
    begin
        bc    = (in_ch.bit_count > 4'd8) ? 4'd8 : in_ch.bit_count;
        data  = {5'd0, in_ch.in_bits} & ((13'd1 << bc) - 13'd1);
        acc   = ({8'd0, leftover_bits_reg} << bc) | data;
        total = {1'b0, leftover_count_reg} + bc;

        d        = '0;
        d.last   = in_ch.last;
        rem      = total;
        if (total >= 4'd12)
        begin
            d.groups[0] = group_t'(acc >> (total - 4'd6));
            d.groups[1] = group_t'(acc >> (total - 4'd12));
            d.n_data    = 2'd2;
            rem         = total - 4'd12;
        end
        else if (total >= 4'd6)
        begin
            d.groups[0] = group_t'(acc >> (total - 4'd6));
            d.n_data    = 2'd1;
            rem         = total - 4'd6;
        end
        rem_val = 5'(acc & ((13'd1 << rem) - 13'd1));

        seen_next = seen_reg || (bc != 4'd0);

        // Zero-fill the partial group on the final item.
        if (in_ch.last && rem != 4'd0)
        begin
            case (d.n_data)
                2'd0:    d.groups[0] = group_t'({1'b0, rem_val} << (4'd6 - rem));
                2'd1:    d.groups[1] = group_t'({1'b0, rem_val} << (4'd6 - rem));
                default: d.groups[2] = group_t'({1'b0, rem_val} << (4'd6 - rem));
            endcase
            d.n_data = d.n_data + 2'd1;
        end

        phase_next = phase_reg + d.n_data;
        if (in_ch.last && seen_next)
        begin
            d.n_pad = 2'd0 - phase_next;
        end

        n_chars = {1'b0, d.n_data} + {1'b0, d.n_pad};

        leftover_bits_next  = rem_val;
        leftover_count_next = rem[2:0];
        if (in_ch.last)
        begin
            leftover_bits_next  = '0;
            leftover_count_next = '0;
            phase_next          = '0;
            seen_next           = 1'b0;
        end
    end

    // Items that cause no character are dropped here.
    assign push      = accept && (n_chars != 3'd0);
    assign push_desc = d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leftover_bits_reg  <= '0;
            leftover_count_reg <= '0;
            phase_reg          <= '0;
            seen_reg           <= 1'b0;
        end
        else if (accept)
        begin
            leftover_bits_reg  <= leftover_bits_next;
            leftover_count_reg <= leftover_count_next;
            phase_reg          <= phase_next;
            seen_reg           <= seen_next;
        end
    end

endmodule

// File: sv/b64e_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry descriptor queue between the group former and the char emitter.
// ----------------------------------------------------------------------------
module b64e_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b64e_pkg::desc_t push_desc,
    output logic            push_ready,
    input  logic            pop,
    output logic            head_valid,
    output b64e_pkg::desc_t head_desc
);
    import b64e_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    desc_t            mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign push_ready = (count_reg != (PTR_W+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && push_ready)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && push_ready)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && head_valid)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PTR_W+1)'(push && push_ready)
                                   - (PTR_W+1)'(pop && head_valid);
        end
    end

endmodule

// File: sv/b64e_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Steps through the head descriptor: one character per cycle while ready.
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  b64e_pkg::desc_t head_desc,
    output logic            pop,
    b64e_out_if.source      out_ch
);
    import b64e_pkg::*;

    logic [2:0]        idx_reg, idx_next;
    logic              valid_reg;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              run_reg, stream_reg;
    logic [2:0]        n_total;
    logic              load;
    logic              final_char;

    assign load       = head_valid && (!valid_reg || out_ch.ready);
    assign n_total    = {1'b0, head_desc.n_data} + {1'b0, head_desc.n_pad};
    assign final_char = (idx_reg == n_total - 3'd1);
    assign pop        = load && final_char;

    always_comb
    begin
        char_next = CH_PAD;
        if (idx_reg < {1'b0, head_desc.n_data})
        begin
            case (idx_reg[1:0])
                2'd0:    char_next = map_group(head_desc.groups[0]);
                2'd1:    char_next = map_group(head_desc.groups[1]);
                default: char_next = map_group(head_desc.groups[2]);
            endcase
        end
        idx_next = final_char ? 3'd0 : idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg   <= idx_next;
                valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg   <= char_next;
            run_reg    <= final_char;
            stream_reg <= final_char && head_desc.last;
        end
    end

    assign out_ch.valid         = valid_reg;
    assign out_ch.out_char      = char_reg;
    assign out_ch.end_of_run    = run_reg;
    assign out_ch.end_of_stream = stream_reg;

endmodule

// File: sv/base64url_bit_encoder.sv
// An accepted item is registered into the descriptor queue, and each of its characters
// then passes through the output register. One character per cycle leaves the output
// register while the receiver is ready; an item holds the emitter until all its characters
// are out. Input stalls only when the two-entry descriptor queue is full.
// Reset (rst_n, async, active low) clears stream state, queue and output valid.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64url_bit_encoder
// Streaming URL-safe base64 encoder over a bit stream of any length.
// ----------------------------------------------------------------------------
module base64url_bit_encoder (
    input  logic        clk,
    input  logic        rst_n,
    b64e_in_if.sink     in_ch,
    b64e_out_if.source  out_ch
);
    import b64e_pkg::*;

    logic  q_push, q_ready, q_pop, q_valid;
    desc_t q_in_desc, q_head_desc;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push       (q_push),
        .push_desc  (q_in_desc),
        .push_ready (q_ready)
    );

    b64e_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_desc  (q_in_desc),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_desc  (q_head_desc)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_desc  (q_head_desc),
        .pop        (q_pop),
        .out_ch     (out_ch)
    );

`ifndef SYNTHESIS
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop of empty descriptor queue");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_ready)
        else $error("push into full descriptor queue");

    a_stream_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.end_of_stream |-> out_ch.end_of_run)
        else $error("end_of_stream without end_of_run");

    a_no_empty_desc: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (q_head_desc.n_data != 2'd0 || q_head_desc.n_pad != 2'd0))
        else $error("queued descriptor carries no characters");
`endif

endmodule

// File: dv/tb_base64url_bit_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64url_bit_encoder
// Self-checking bench for the streaming base64url bit encoder. Bit items go in
// as directed streams first, then as random streams. A scoreboard predicts
// every character with its end flags, and each character that comes out is
// compared against it. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_base64url_bit_encoder;

    import b64e_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eor;
        logic              eos;
    } b64_char_t;

    // Running encoder state plus the queue of characters still owed by the block.
    class char_scoreboard;
        logic [4:0] tail_bits;
        logic [2:0] tail_count;
        logic [1:0] phase;
        bit         seen;
        b64_char_t  expected_q[$];

        function new();
            reset_stream();
        endfunction

        function void reset_stream();
            tail_bits  = '0;
            tail_count = '0;
            phase      = '0;
            seen       = 1'b0;
        endfunction

        function logic [CHAR_W-1:0] encode_group(logic [5:0] g);
            if (g < 6'd26)
            begin
                return CH_UPPER_A + CHAR_W'(g);
            end
            if (g < 6'd52)
            begin
                return CH_LOWER_A + CHAR_W'(g - 6'd26);
            end
            if (g < 6'd62)
            begin
                return CH_ZERO + CHAR_W'(g - 6'd52);
            end
            return (g == 6'd62) ? CH_DASH : CH_UNDER;
        endfunction

        function void note_item(logic [7:0] bits, logic [3:0] cnt, logic lst);
            int unsigned bc;
            int unsigned total;
            int          n;
            logic [12:0] acc;
            b64_char_t   run[6];
            bc    = (cnt > 4'd8) ? 8 : int'(cnt);
            acc   = ({8'd0, tail_bits} << bc) | ({5'd0, bits} & ((13'd1 << bc) - 13'd1));
            total = int'(tail_count) + bc;
            n     = 0;
            if (bc > 0)
            begin
                seen = 1'b1;
            end
            while (total >= 6)
            begin
                total  = total - 6;
                run[n] = '{ch: encode_group(6'(acc >> total)), eor: 1'b0, eos: 1'b0};
                n      = n + 1;
                phase  = phase + 2'd1;
            end
            acc = acc & ((13'd1 << total) - 13'd1);
            if (lst)
            begin
                // Flush a partial group zero-filled, then pad to a multiple of four.
                if (total > 0)
                begin
                    run[n] = '{ch: encode_group(6'(acc << (6 - total))), eor: 1'b0, eos: 1'b0};
                    n      = n + 1;
                    phase  = phase + 2'd1;
                end
                if (seen)
                begin
                    while (phase != 2'd0)
                    begin
                        run[n] = '{ch: CH_PAD, eor: 1'b0, eos: 1'b0};
                        n      = n + 1;
                        phase  = phase + 2'd1;
                    end
                end
                if (n > 0)
                begin
                    run[n-1].eos = 1'b1;
                end
                reset_stream();
            end
            else
            begin
                tail_bits  = acc[4:0];
                tail_count = total[2:0];
            end
            if (n > 0)
            begin
                run[n-1].eor = 1'b1;
            end
            for (int i = 0; i < n; i++)
            begin
                expected_q = {expected_q, run[i]};
            end
        endfunction

        function string check_char(b64_char_t got);
            b64_char_t want;
            string     msg;
            if (expected_q.size() == 0)
            begin
                return $sformatf("unexpected char 0x%02h", got.ch);
            end
            want = expected_q.pop_front();
            msg  = "";
            if (got.ch != want.ch)
            begin
                msg = {msg, $sformatf(" out_char 0x%02h/0x%02h", got.ch, want.ch)};
            end
            if (got.eor != want.eor)
            begin
                msg = {msg, $sformatf(" end_of_run %0b/%0b", got.eor, want.eor)};
            end
            if (got.eos != want.eos)
            begin
                msg = {msg, $sformatf(" end_of_stream %0b/%0b", got.eos, want.eos)};
            end
            if (msg != "")
            begin
                msg = {"mismatch (got/want):", msg};
            end
            return msg;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    b64e_in_if  in_ch ();
    b64e_out_if out_ch ();

    base64url_bit_encoder uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    char_scoreboard sb;
    int             errors;
    int             items_sent;
    int             burst_left;
    bit             hold_req;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #2000000;
        $display("base64url_bit_encoder test failed");
        $finish;
    end

    task automatic report(string msg);
        errors = errors + 1;
        if (errors <= 30)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic send_item(logic [7:0] bits, logic [3:0] cnt, logic lst);
        in_ch.valid     <= 1'b1;
        in_ch.in_bits   <= bits;
        in_ch.bit_count <= cnt;
        in_ch.last      <= lst;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_item(bits, cnt, lst);
        items_sent = items_sent + 1;
        if (burst_left > 0)
        begin
            burst_left = burst_left - 1;
        end
        else
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 10);
        end
    endtask

    // Stop offering until the block has returned every owed character.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic random_stream();
        int          len;
        int          r;
        logic [3:0]  cnt;
        len = $urandom_range(1, 14);
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                cnt = 4'($urandom_range(9, 15));
            end
            else if (r < 20)
            begin
                cnt = 4'd0;
            end
            else if (r < 60)
            begin
                cnt = 4'd8;
            end
            else
            begin
                cnt = 4'($urandom_range(1, 7));
            end
            send_item(8'($urandom_range(0, 255)), cnt, i == len - 1);
        end
    endtask

    // Output side: check accepted characters, then pick next cycle's ready.
    initial
    begin
        b64_char_t got;
        string     msg;
        int        stall_mode;
        int        mode_left;
        int        hold_left;
        stall_mode = 0;
        mode_left  = 0;
        hold_left  = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got.ch  = out_ch.out_char;
                got.eor = out_ch.end_of_run;
                got.eos = out_ch.end_of_stream;
                msg     = sb.check_char(got);
                if (msg != "")
                begin
                    report(msg);
                end
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 120;
            end
            if (!rst_n)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(10, 60);
                end
                mode_left = mode_left - 1;
                case (stall_mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        bit hold_done;
        bit drain_done;
        sb         = new();
        errors     = 0;
        items_sent = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        rst_n      = 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.in_bits   <= '0;
        in_ch.bit_count <= '0;
        in_ch.last      <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all ones, full groups only: no padding
        send_item(8'hFF, 4'd8, 1'b0);
        send_item(8'hFF, 4'd8, 1'b0);
        send_item(8'hFF, 4'd8, 1'b1);
        // empty streams, with and without ignored bits
        send_item(8'h00, 4'd0, 1'b1);
        send_item(8'hAB, 4'd0, 1'b0);
        send_item(8'h5A, 4'd0, 1'b1);
        // oversized counts clamp to eight bits
        send_item(8'hF8, 4'd15, 1'b0);
        send_item(8'h00, 4'd9, 1'b0);
        send_item(8'h3E, 4'd12, 1'b1);
        // bits above the count are dropped
        send_item(8'hFF, 4'd3, 1'b0);
        send_item(8'hF0, 4'd1, 1'b1);
        // whole groups and a bit-less last item: nothing comes out for it
        send_item(8'h12, 4'd8, 1'b0);
        send_item(8'h34, 4'd8, 1'b0);
        send_item(8'h56, 4'd8, 1'b0);
        send_item(8'h00, 4'd0, 1'b1);
        // single bit: one char and three pads
        send_item(8'h01, 4'd1, 1'b1);
        // dash and underscore, two pads
        send_item(8'h3E, 4'd6, 1'b0);
        send_item(8'h3F, 4'd6, 1'b1);
        // zeros in two whole groups, two pads
        send_item(8'h00, 4'd8, 1'b0);
        send_item(8'h00, 4'd4, 1'b1);
        // one pad
        send_item(8'hFB, 4'd8, 1'b0);
        send_item(8'hEF, 4'd8, 1'b1);
        drain();

        while (items_sent < 205)
        begin
            if (!hold_done && items_sent > 90)
            begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (!drain_done && items_sent > 160)
            begin
                drain_done = 1'b1;
                drain();
            end
            random_stream();
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("base64url_bit_encoder test passed");
        end
        else
        begin
            $display("base64url_bit_encoder test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/b64e_pkg.sv
sv/b64e_ifs.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64url_bit_encoder.sv
dv/tb_base64url_bit_encoder.sv
